### sv/zts_pkg.sv
// Shared types and constants for the zero-temperature subband density block.
package zts_pkg;

  localparam int DATA_W  = 32;
  localparam int ACC_W   = 48;
  localparam int DIV_W   = 64;
  localparam int CFG_IW  = 2;
  localparam int CHUNK_W = 16;
  localparam int MUL_STEPS = ACC_W / CHUNK_W;

  localparam logic [ACC_W-1:0]  MAX48 = {ACC_W{1'b1}};
  localparam logic [DATA_W-1:0] MAX32 = {DATA_W{1'b1}};

  localparam logic [CFG_IW-1:0] REG_FERMI  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_POINTS = 2'd1;
  localparam logic [CFG_IW-1:0] REG_DOS    = 2'd2;

  typedef enum logic [1:0] {
    FN_MASS   = 2'd0,
    FN_SAMPLE = 2'd1,
    FN_READ   = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISP,
    ST_MASS_DIV,
    ST_MASS_WR,
    ST_SMP_ACC,
    ST_SMP_ADD,
    ST_END_CHK,
    ST_END_DIV,
    ST_TERM_WAIT,
    ST_WALK_RD,
    ST_WALK_MUL,
    ST_WALK_WAIT,
    ST_RD_OUT
  } st_t;

  typedef struct packed {
    logic latch;
    logic div_mass;
    logic div_dos;
    logic recip_wr;
    logic smp_sq;
    logic smp_acc;
    logic ims_add;
    logic set_stop;
    logic mul_term;
    logic term_wr;
    logic walk_rd;
    logic mul_walk;
    logic walk_wr;
    logic dens_rd_idx;
    logic out_load;
    logic clr_acc;
    logic cnt_zero;
    logic sweep_wr;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  idx_ok;
    logic  sv_pos;
    logic  in_used;
    logic  stopped;
    logic  above;
    logic  last;
    logic  ims_zero;
    logic  div_done;
    logic  mul_done;
    logic  walk_last;
    logic  sweep_last;
    logic  out_free;
  } stat_t;

endpackage

### sv/zts_div.sv
// Restoring divider, one quotient bit per cycle.
module zts_div import zts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [ACC_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] q;
  logic [ACC_W-1:0] rem;
  logic [ACC_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic [ACC_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem, q[DIV_W-1]};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= fits ? ACC_W'(trial - {1'b0, dsr}) : trial[ACC_W-1:0];
        q   <= {q[DIV_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;

endmodule

### sv/zts_mul.sv
// 48 by 48 multiply in 16-bit chunks, scaled down and saturated to 48 bits.
module zts_mul import zts_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACC_W-1:0] a,
  input  logic [ACC_W-1:0] b,
  output logic             busy,
  output logic             done,
  output logic [ACC_W-1:0] result
);

  localparam int PW = ACC_W + CHUNK_W;
  localparam int AW = 2 * ACC_W;
  localparam logic [1:0] LAST = 2'(MUL_STEPS);

  logic [ACC_W-1:0]   ar;
  logic [ACC_W-1:0]   br;
  logic [1:0]         step;
  logic [PW-1:0]      pp;
  logic [AW-1:0]      acc;
  logic [CHUNK_W-1:0] chunk;
  logic [AW-1:0]      pp_sh;
  logic [AW-1:0]      acc_sh;

  always_comb begin
    case (step)
      2'd0:    chunk = br[CHUNK_W-1:0];
      2'd1:    chunk = br[2*CHUNK_W-1:CHUNK_W];
      2'd2:    chunk = br[3*CHUNK_W-1:2*CHUNK_W];
      default: chunk = '0;
    endcase
    case (step)
      2'd1:    pp_sh = AW'(pp);
      2'd2:    pp_sh = AW'(pp) << CHUNK_W;
      2'd3:    pp_sh = AW'(pp) << (2 * CHUNK_W);
      default: pp_sh = '0;
    endcase
    acc_sh = acc >> FRAC_BITS;
    result = (|acc_sh[AW-1:ACC_W]) ? MAX48 : acc_sh[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        ar   <= a;
        br   <= b;
        acc  <= '0;
      end else if (busy) begin
        pp   <= ar * chunk;
        acc  <= acc + pp_sh;
        step <= step + 1'b1;
        if (step == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/zts_ctrl.sv
// Controller state machine: sequences items, subband end, walks and clears.
module zts_ctrl import zts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (stat.sweep_last) state_next = ST_IDLE;
      ST_IDLE:     if (in_valid) state_next = ST_DISP;
      ST_DISP: begin
        case (stat.func)
          FN_MASS: begin
            if (!stat.idx_ok)     state_next = ST_IDLE;
            else if (stat.sv_pos) state_next = ST_MASS_DIV;
            else                  state_next = ST_MASS_WR;
          end
          FN_SAMPLE: begin
            if (!stat.in_used || stat.stopped || stat.above) state_next = ST_IDLE;
            else                                             state_next = ST_SMP_ACC;
          end
          FN_READ:  state_next = ST_RD_OUT;
          FN_CLEAR: state_next = ST_CLEAR;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_MASS_DIV:  if (stat.div_done) state_next = ST_MASS_WR;
      ST_MASS_WR:   state_next = ST_IDLE;
      ST_SMP_ACC:   state_next = ST_SMP_ADD;
      ST_SMP_ADD:   state_next = stat.last ? ST_END_CHK : ST_IDLE;
      ST_END_CHK:   state_next = stat.ims_zero ? ST_TERM_WAIT : ST_END_DIV;
      ST_END_DIV:   if (stat.div_done) state_next = ST_TERM_WAIT;
      ST_TERM_WAIT: if (stat.mul_done) state_next = ST_WALK_RD;
      ST_WALK_RD:   state_next = ST_WALK_MUL;
      ST_WALK_MUL:  state_next = ST_WALK_WAIT;
      ST_WALK_WAIT: begin
        if (stat.mul_done) state_next = stat.walk_last ? ST_IDLE : ST_WALK_RD;
      end
      ST_RD_OUT:    if (stat.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.sweep_wr = 1'b1;
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_DISP: begin
        case (stat.func)
          FN_MASS:   cmd.div_mass = stat.idx_ok && stat.sv_pos;
          FN_SAMPLE: begin
            cmd.set_stop = stat.in_used && !stat.stopped && stat.above;
            cmd.smp_sq   = stat.in_used && !stat.stopped && !stat.above;
          end
          FN_READ:   cmd.dens_rd_idx = 1'b1;
          FN_CLEAR: begin
            cmd.clr_acc  = 1'b1;
            cmd.cnt_zero = 1'b1;
          end
          default: ;
        endcase
      end
      ST_MASS_WR:   cmd.recip_wr = 1'b1;
      ST_SMP_ACC:   cmd.smp_acc = 1'b1;
      ST_SMP_ADD:   cmd.ims_add = 1'b1;
      ST_END_CHK: begin
        cmd.div_dos  = !stat.ims_zero;
        cmd.mul_term = stat.ims_zero;
      end
      ST_END_DIV:   cmd.mul_term = stat.div_done;
      ST_TERM_WAIT: begin
        cmd.term_wr  = stat.mul_done;
        cmd.cnt_zero = stat.mul_done;
      end
      ST_WALK_RD:   cmd.walk_rd = 1'b1;
      ST_WALK_MUL:  cmd.mul_walk = 1'b1;
      ST_WALK_WAIT: cmd.walk_wr = stat.mul_done;
      ST_RD_OUT:    cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

### sv/zts_datapath.sv
// Datapath: config registers, grid memories, accumulators and output register.
module zts_datapath import zts_pkg::*; #(
  parameter int GRID_MAX  = 256,
  parameter int FRAC_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IW-1:0]        cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic [1:0]               func,
  input  logic [7:0]               grid_index,
  input  logic signed [DATA_W-1:0] sample_value,
  input  logic signed [DATA_W-1:0] subband_energy,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               read_index,
  output logic [ACC_W-1:0]         density_value,
  output logic [ACC_W-1:0]         sheet_density,
  input  cmd_t                     cmd,
  output stat_t                    stat
);

  localparam int AW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int CW = $clog2(GRID_MAX + 1);

  logic signed [DATA_W-1:0] fermi;
  logic [8:0]               gpts;
  logic [DATA_W-1:0]        dos_scale;

  func_t                    it_func;
  logic [7:0]               it_idx;
  logic signed [DATA_W-1:0] it_sv;
  logic signed [DATA_W-1:0] it_energy;

  logic [DATA_W-1:0] recip_mem [GRID_MAX];
  logic [DATA_W-1:0] sq_mem    [GRID_MAX];
  logic [ACC_W-1:0]  dens_mem  [GRID_MAX];
  logic [DATA_W-1:0] recip_rd;
  logic [DATA_W-1:0] sq_rd;
  logic [ACC_W-1:0]  dens_rd;

  logic [ACC_W-1:0]    ims;
  logic [ACC_W-1:0]    sheet;
  logic                stopped;
  logic [ACC_W-1:0]    term;
  logic [2*DATA_W-1:0] sqp;
  logic [2*DATA_W-1:0] prod;
  logic [CW-1:0]       cnt;

  logic [CW-1:0]       used_n;
  logic [AW-1:0]       idx_a;
  logic [AW-1:0]       cnt_a;
  logic [DATA_W-1:0]   mag;
  logic [2*DATA_W-1:0] sqs;
  logic [DATA_W-1:0]   sq;
  logic [2*DATA_W-1:0] prod_sh;
  logic signed [DATA_W:0] de;

  logic             div_start, div_busy, div_done;
  logic [DIV_W-1:0] div_dvd, div_q;
  logic [ACC_W-1:0] div_dsr, dos;
  logic             mul_start, mul_busy, mul_done;
  logic [ACC_W-1:0] mul_a, mul_b, mul_res;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] x,
                                               input logic [ACC_W-1:0] y);
    logic [ACC_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[ACC_W] ? MAX48 : s[ACC_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      fermi     <= '0;
      gpts      <= 9'd256;
      dos_scale <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FERMI:  fermi <= cfg_data;
        REG_POINTS: gpts <= cfg_data[8:0];
        REG_DOS:    dos_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_func   <= func_t'(func);
      it_idx    <= grid_index;
      it_sv     <= sample_value;
      it_energy <= subband_energy;
    end
  end

  always_comb begin
    if (gpts == 9'd0)             used_n = CW'(1);
    else if (32'(gpts) > GRID_MAX) used_n = CW'(GRID_MAX);
    else                           used_n = CW'(gpts);
    idx_a   = AW'(it_idx);
    cnt_a   = cnt[AW-1:0];
    mag     = it_sv[DATA_W-1] ? DATA_W'(-it_sv) : DATA_W'(it_sv);
    sqs     = sqp >> FRAC_BITS;
    sq      = (|sqs[2*DATA_W-1:DATA_W]) ? MAX32 : sqs[DATA_W-1:0];
    prod_sh = prod >> FRAC_BITS;
    de      = $signed({fermi[DATA_W-1], fermi}) - $signed({it_energy[DATA_W-1], it_energy});
    dos     = (|div_q[DIV_W-1:ACC_W]) ? MAX48 : div_q[ACC_W-1:0];
  end

  // Divider serves both the reciprocal mass and the state density.
  assign div_start = cmd.div_mass | cmd.div_dos;
  assign div_dvd   = cmd.div_mass ? (DIV_W'(1) << (2 * FRAC_BITS))
                                  : (DIV_W'(dos_scale) << FRAC_BITS);
  assign div_dsr   = cmd.div_mass ? ACC_W'(unsigned'(it_sv)) : ims;

  zts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign mul_start = cmd.mul_term | cmd.mul_walk;
  assign mul_a     = cmd.mul_term ? (ims == '0 ? MAX48 : dos) : term;
  assign mul_b     = cmd.mul_term ? ACC_W'(unsigned'(de)) : ACC_W'(sq_rd);

  zts_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.recip_wr) begin
      recip_mem[idx_a] <= it_sv[DATA_W-1] || it_sv == '0 ? MAX32
                        : ((|div_q[DIV_W-1:DATA_W]) ? MAX32 : div_q[DATA_W-1:0]);
    end
    if (cmd.smp_sq) recip_rd <= recip_mem[idx_a];
    if (cmd.smp_acc) sq_mem[idx_a] <= sq;
    if (cmd.walk_rd) sq_rd <= sq_mem[cnt_a];
    if (cmd.walk_rd)          dens_rd <= dens_mem[cnt_a];
    else if (cmd.dens_rd_idx) dens_rd <= dens_mem[idx_a];
    if (cmd.sweep_wr)     dens_mem[cnt_a] <= '0;
    else if (cmd.walk_wr) dens_mem[cnt_a] <= sat_add(dens_rd, mul_res);
  end

  always_ff @(posedge clk) begin
    if (cmd.smp_sq)  sqp <= mag * mag;
    if (cmd.smp_acc) prod <= sq * recip_rd;
    if (cmd.term_wr) term <= mul_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ims     <= '0;
      sheet   <= '0;
      stopped <= 1'b0;
      cnt     <= '0;
    end else begin
      if (cmd.clr_acc) begin
        ims     <= '0;
        sheet   <= '0;
        stopped <= 1'b0;
      end
      if (cmd.set_stop) begin
        stopped <= 1'b1;
        ims     <= '0;
      end
      if (cmd.ims_add) ims <= sat_add(ims, ACC_W'(prod_sh));
      if (cmd.term_wr) sheet <= sat_add(sheet, mul_res);
      if (cmd.walk_wr && stat.walk_last) ims <= '0;
      if (cmd.cnt_zero)                      cnt <= '0;
      else if (cmd.sweep_wr || cmd.walk_wr) cnt <= cnt + 1'b1;
    end
  end

  // Hold a result until the sink takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_index    <= it_idx;
      density_value <= stat.idx_ok ? dens_rd : '0;
      sheet_density <= sheet;
    end
  end

  always_comb begin
    stat.func       = it_func;
    stat.idx_ok     = 32'(it_idx) < GRID_MAX;
    stat.sv_pos     = !it_sv[DATA_W-1] && it_sv != '0;
    stat.in_used    = 32'(it_idx) < 32'(used_n);
    stat.stopped    = stopped;
    stat.above      = it_energy > fermi;
    stat.last       = 32'(it_idx) == 32'(used_n) - 1;
    stat.ims_zero   = ims == '0;
    stat.div_done   = div_done;
    stat.mul_done   = mul_done;
    stat.walk_last  = 32'(cnt) == 32'(used_n) - 1;
    stat.sweep_last = 32'(cnt) == GRID_MAX - 1;
    stat.out_free   = !out_valid || out_ready;
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending beat");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_wr && stat.walk_last) |=> (ims == '0))
    else $error("mass sum not cleared at subband end");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_wr || cmd.sweep_wr) |-> (32'(cnt) < GRID_MAX))
    else $error("grid counter out of range");

endmodule

### sv/zero_temp_subband_density.sv
// A read loads the output register once it is free; a mass load with a positive value
// runs the 64-step divider; a sample is squared, scaled and added to the mass sum; a
// subband's last sample adds a divide (skipped for a zero mass sum), a chunked multiply
// and a density walk over the used grid points. Items are taken one at a time.
// Reset (synchronous, rst high) clears control state, then sweeps all GRID_MAX density
// memory entries with in_ready low; configuration writes are taken.
module zero_temp_subband_density import zts_pkg::*; #(
  parameter int GRID_MAX  = 256,
  parameter int FRAC_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IW-1:0]        cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               func,
  input  logic [7:0]               grid_index,
  input  logic signed [DATA_W-1:0] sample_value,
  input  logic signed [DATA_W-1:0] subband_energy,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               read_index,
  output logic [ACC_W-1:0]         density_value,
  output logic [ACC_W-1:0]         sheet_density
);

  cmd_t  cmd;
  stat_t stat;

  zts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  zts_datapath #(.GRID_MAX(GRID_MAX), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .func           (func),
    .grid_index     (grid_index),
    .sample_value   (sample_value),
    .subband_energy (subband_energy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_index     (read_index),
    .density_value  (density_value),
    .sheet_density  (sheet_density),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

### tb/zero_temp_subband_density_test.sv
// Self-checking testbench for the zero-temperature subband density block.
module zero_temp_subband_density_test;
  import zts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 24;
  localparam int NGRID = 256;
  localparam int SETTLE = 2000;

  typedef struct {
    logic [7:0]  idx;
    logic [47:0] dens;
    logic [47:0] sheet;
  } density_beat_t;

  typedef struct {
    func_t       fn;
    logic [7:0]  idx;
    logic [31:0] sv;
    logic [31:0] en;
    bit          typed;
    logic [47:0] dens;
    logic [47:0] sheet;
  } stim_row_t;

  typedef struct {
    logic [31:0] fermi;
    logic [8:0]  npts;
    logic [31:0] dos;
    int          items;
  } phase_cfg_t;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] func;
  logic [7:0] grid_index;
  logic signed [31:0] sample_value, subband_energy;
  logic out_valid, out_ready;
  logic [7:0] read_index;
  logic [47:0] density_value, sheet_density;

  zero_temp_subband_density i_dut (.*);

  // predictor state
  logic signed [31:0] fermi_q;
  logic [8:0]  npts_q;
  logic [31:0] dos_q;
  logic [31:0] recip_mem [NGRID];
  logic [31:0] sq_mem [NGRID];
  logic [47:0] dens_mem [NGRID];
  bit          mass_set [NGRID];
  bit          sq_set [NGRID];
  logic [47:0] inv_mass_sum, sheet_sum;
  bit          halted;

  density_beat_t density_q[$];
  int  errors, mismatches;
  bit  quiet, hold_req, hold_taken;
  int  stall_cnt;

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = a + b;
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic logic [47:0] mul_shift48(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    p = p >> FRAC;
    return (p > MAX48) ? MAX48 : p[47:0];
  endfunction

  function automatic int used_pts();
    if (npts_q == 0) return 1;
    return (npts_q > NGRID) ? NGRID : npts_q;
  endfunction

  // an item is unsafe if it would make the block read a store entry never written
  function automatic bit touches_unwritten(input func_t fn, input logic [7:0] idx,
                                           input logic [31:0] en);
    int n;
    n = used_pts();
    if (fn != FN_SAMPLE || halted || idx >= n || $signed(en) > fermi_q) return 0;
    if (!mass_set[idx]) return 1;
    if (idx == n - 1)
      for (int j = 0; j < n - 1; j++)
        if (!sq_set[j]) return 1;
    return 0;
  endfunction

  task automatic close_subband(input logic [31:0] en);
    logic signed [63:0] de;
    logic [63:0] st_dens, num;
    logic [47:0] term;
    de = 64'($signed(fermi_q)) - 64'($signed(en));
    if (inv_mass_sum == 0) begin
      st_dens = MAX48;
    end else begin
      num = {32'd0, dos_q} << FRAC;
      st_dens = num / inv_mass_sum;
      if (st_dens > MAX48) st_dens = MAX48;
    end
    term = mul_shift48(st_dens, de);
    sheet_sum = sat_add48(sheet_sum, term);
    for (int j = 0; j < used_pts(); j++)
      dens_mem[j] = sat_add48(dens_mem[j], mul_shift48(sq_mem[j], term));
    inv_mass_sum = 0;
  endtask

  task automatic predict_density(input func_t fn, input logic [7:0] idx, input logic [31:0] sv,
                                 input logic [31:0] en, output bit has_beat,
                                 output density_beat_t beat);
    logic signed [63:0] s64;
    logic [63:0] mag, sq, r;
    has_beat = 0;
    beat = '{default: '0};
    s64 = $signed(sv);
    case (fn)
      FN_MASS: begin
        r = MAX32;
        if (s64 > 0) begin
          r = (64'd1 << (2 * FRAC)) / s64;
          if (r > MAX32) r = MAX32;
        end
        recip_mem[idx] = r[31:0];
        mass_set[idx] = 1;
      end
      FN_SAMPLE: begin
        if (!halted && idx < used_pts()) begin
          if ($signed(en) > fermi_q) begin
            halted = 1;
            inv_mass_sum = 0;
          end else begin
            mag = (s64 < 0) ? -s64 : s64;
            sq = (mag * mag) >> FRAC;
            if (sq > MAX32) sq = MAX32;
            sq_mem[idx] = sq[31:0];
            sq_set[idx] = 1;
            inv_mass_sum = sat_add48(inv_mass_sum, 48'((sq * recip_mem[idx]) >> FRAC));
            if (idx == used_pts() - 1) close_subband(en);
          end
        end
      end
      FN_READ: begin
        has_beat = 1;
        beat.idx = idx;
        beat.dens = dens_mem[idx];
        beat.sheet = sheet_sum;
      end
      default: begin
        foreach (dens_mem[j]) dens_mem[j] = 0;
        inv_mass_sum = 0;
        sheet_sum = 0;
        halted = 0;
      end
    endcase
  endtask

  task automatic offer_item(input func_t fn, input logic [7:0] idx, input logic [31:0] sv,
                            input logic [31:0] en);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1;
    func <= fn;
    grid_index <= idx;
    sample_value <= sv;
    subband_energy <= en;
    do @(posedge clk); while (!in_ready);
  endtask

  // predict and send; an unsafe sample turns into a read of the same point
  task automatic send_predicted(input func_t fn_in, input logic [7:0] idx,
                                input logic [31:0] sv, input logic [31:0] en);
    func_t fn;
    bit has_beat;
    density_beat_t beat;
    fn = touches_unwritten(fn_in, idx, en) ? FN_READ : fn_in;
    predict_density(fn, idx, sv, en, has_beat, beat);
    if (has_beat) density_q.push_back(beat);
    offer_item(fn, idx, sv, en);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] ri, input logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= ri;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (ri)
      REG_FERMI:  fermi_q = val;
      REG_POINTS: npts_q = val[8:0];
      default:    dos_q = val;
    endcase
  endtask

  task automatic drain();
    in_valid <= 0;
    while (density_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 1 << 25) * ($urandom_range(0, 1) ? 1 : -1);
  endfunction

  function automatic logic [31:0] rand_mass();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(1 << 22, 1 << 26);
  endfunction

  function automatic logic [31:0] pick_energy(input bit above);
    logic signed [63:0] e;
    if (above && fermi_q != 32'sh7fffffff)
      e = 64'(fermi_q) + 1 + $urandom_range(0, 1 << 24);
    else
      e = 64'(fermi_q) - $urandom_range(0, 1 << 26);
    if (e > 64'sh7fffffff) e = 64'sh7fffffff;
    if (e < -64'sh80000000) e = -64'sh80000000;
    return e[31:0];
  endfunction

  task automatic run_phase(input phase_cfg_t pc);
    int cnt, n, r;
    logic [31:0] en;
    write_reg(REG_FERMI, pc.fermi);
    write_reg(REG_POINTS, 32'(pc.npts));
    write_reg(REG_DOS, pc.dos);
    n = used_pts();
    for (int j = 0; j < n; j++)
      send_predicted(FN_MASS, 8'(j), $urandom_range(1 << 22, 1 << 26), 0);
    cnt = 0;
    while (cnt < pc.items) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        en = pick_energy($urandom_range(0, 19) == 0);
        for (int j = 0; j < n; j++) begin
          send_predicted(FN_SAMPLE, 8'(j), rand_sample(), en);
          if ($urandom_range(0, 29) == 0)
            send_predicted(FN_READ, 8'($urandom_range(0, n - 1)), $urandom, $urandom);
        end
        cnt += n;
      end else begin
        if (r < 75)
          send_predicted(FN_READ, 8'($urandom_range(0, 255)), $urandom, $urandom);
        else if (r < 80)
          send_predicted(FN_CLEAR, 8'($urandom), $urandom, $urandom);
        else if (r < 88)
          send_predicted(FN_MASS, 8'($urandom_range(0, 255)), rand_mass(), $urandom);
        else
          send_predicted(func_t'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom);
        cnt++;
      end
    end
    drain();
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      stall_cnt <= 0;
      hold_taken <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1;
      stall_cnt <= 400;
      out_ready <= 0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_cnt <= $urandom_range(0, 18);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    density_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (density_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected beat: index %0d", read_index);
      end else begin
        want = density_q.pop_front();
        if (read_index !== want.idx || density_value !== want.dens ||
            sheet_density !== want.sheet) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: idx %0d/%0d density %0h/%0h sheet %0h/%0h (exp/act)",
                     want.idx, read_index, want.dens, density_value, want.sheet,
                     sheet_density);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    phase_cfg_t phases[$];
    bit has_beat;
    density_beat_t beat;
    rst <= 1;
    cfg_we <= 0;
    cfg_index <= REG_FERMI;
    cfg_data <= 0;
    in_valid <= 0;
    func <= FN_READ;
    grid_index <= 0;
    sample_value <= 0;
    subband_energy <= 0;
    errors = 0;
    mismatches = 0;
    quiet = 0;
    hold_req = 0;
    fermi_q = 0;
    npts_q = 256;
    dos_q = 0;
    inv_mass_sum = 0;
    sheet_sum = 0;
    halted = 0;
    foreach (dens_mem[j]) begin
      dens_mem[j] = 0;
      recip_mem[j] = 0;
      sq_mem[j] = 0;
      mass_set[j] = 0;
      sq_set[j] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 0;

    write_reg(REG_FERMI, 32'd2 << FRAC);
    write_reg(REG_POINTS, 32'd4);
    write_reg(REG_DOS, 32'd1 << FRAC);
    rows = '{
      '{FN_READ,   0,   0,            0,            1, 0, 0},
      '{FN_READ,   255, 32'hffffffff, 32'hffffffff, 1, 0, 0},
      '{FN_MASS,   0,   32'd1 << FRAC, 0,           0, 0, 0},
      '{FN_MASS,   1,   0,            0,            0, 0, 0},   // zero mass saturates
      '{FN_MASS,   2,   -32'sd5,      0,            0, 0, 0},   // negative mass
      '{FN_MASS,   3,   32'h7fffffff, 0,            0, 0, 0},
      '{FN_MASS,   255, 32'd1,        0,            0, 0, 0},
      '{FN_SAMPLE, 7,   32'd1 << FRAC, 0,           0, 0, 0},   // past the used grid
      '{FN_SAMPLE, 0,   32'h80000000, 32'h80000000, 0, 0, 0},
      '{FN_SAMPLE, 1,   32'd1 << FRAC, 0,           0, 0, 0},
      '{FN_SAMPLE, 2,   -(32'sd1 << 23), 0,         0, 0, 0},
      '{FN_SAMPLE, 3,   32'h7fffffff, 0,            0, 0, 0},   // closes the subband
      '{FN_READ,   3,   0,            0,            0, 0, 0},
      '{FN_READ,   0,   0,            0,            0, 0, 0},
      '{FN_SAMPLE, 0,   32'd1 << FRAC, 32'h7fffffff, 0, 0, 0},  // above Fermi: halt
      '{FN_SAMPLE, 1,   32'd1 << FRAC, 0,           0, 0, 0},   // ignored while halted
      '{FN_READ,   1,   0,            0,            0, 0, 0},
      '{FN_CLEAR,  0,   0,            0,            0, 0, 0},
      '{FN_READ,   2,   0,            0,            1, 0, 0},
      '{FN_SAMPLE, 0,   0,            32'd1 << FRAC, 0, 0, 0},  // zero mass sum
      '{FN_SAMPLE, 1,   0,            32'd1 << FRAC, 0, 0, 0},
      '{FN_SAMPLE, 2,   0,            32'd1 << FRAC, 0, 0, 0},
      '{FN_SAMPLE, 3,   0,            32'd1 << FRAC, 0, 0, 0},
      '{FN_READ,   0,   0,            0,            0, 0, 0}
    };
    foreach (rows[k]) begin
      predict_density(rows[k].fn, rows[k].idx, rows[k].sv, rows[k].en, has_beat, beat);
      if (rows[k].typed) begin
        beat.dens = rows[k].dens;
        beat.sheet = rows[k].sheet;
      end
      if (has_beat) density_q.push_back(beat);
      offer_item(rows[k].fn, rows[k].idx, rows[k].sv, rows[k].en);
    end
    drain();

    phases = '{
      '{32'd1 << FRAC, 9'd4,   32'd1 << FRAC, 180},
      '{32'h7fffffff,  9'd0,   32'hffffffff,  130},
      '{32'h80000000,  9'd1,   32'd0,         130},
      '{32'd3 << FRAC, 9'd16,  32'h00800000,  200},
      '{32'd0,         9'd2,   32'd12345,     130},
      '{32'd5 << FRAC, 9'd511, 32'd1 << 20,   250},
      '{32'd1 << 25,   9'd8,   $urandom,      150},
      '{32'd2 << FRAC, 9'd3,   32'd1 << FRAC, 100}
    };
    foreach (phases[p]) begin
      if (p == 1) hold_req = 1;
      if (p == phases.size() - 1) quiet = 1;
      run_phase(phases[p]);
    end

    if (errors == 0 && density_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
